>>> hw/rtl/tpcm_pkg.sv
// constants, register codes and helper functions for the tile partition ctu mapper
// no dependencies

package tpcm_pkg;

   localparam int CTU_SIZE      = 64;
   localparam int CTU_LOG2      = $clog2(CTU_SIZE);
   localparam int MAX_TILE_COLS = 8;
   localparam int MAX_TILE_ROWS = 8;
   localparam int MIN_TILE_W    = 4;
   localparam int MIN_TILE_H    = 1;

   localparam int ADDR_W  = 14;
   localparam int PIX_W   = 14;
   localparam int DIM_W   = PIX_W - CTU_LOG2 + 1;
   localparam int END_W   = 12;
   localparam int RCP_W   = 16;
   localparam int RCP_SH  = 15;
   localparam int WH_W    = 2 * DIM_W - 1;
   localparam int N_TILES = 8;

   typedef enum logic [2:0] {
      CSR_PIC_WIDTH     = 3'd0,
      CSR_PIC_HEIGHT    = 3'd1,
      CSR_TILE_COLS     = 3'd2,
      CSR_TILE_ROWS     = 3'd3,
      CSR_UNIFORM       = 3'd4,
      CSR_COLUMN_WIDTHS = 3'd5,
      CSR_ROW_HEIGHTS   = 3'd6
   } csr_index_type;

   // ceil(2^15 / n) for tile counts 1..8
   function automatic logic [RCP_W-1:0] recip(input logic [3:0] n);
      case (n)
         4'd1:    recip = 16'd32768;
         4'd2:    recip = 16'd16384;
         4'd3:    recip = 16'd10923;
         4'd4:    recip = 16'd8192;
         4'd5:    recip = 16'd6554;
         4'd6:    recip = 16'd5462;
         4'd7:    recip = 16'd4682;
         4'd8:    recip = 16'd4096;
         default: recip = 16'd32768;
      endcase
   endfunction

   function automatic logic [3:0] clamp_count(input logic [3:0] v, input logic [3:0] maxv);
      if (v == 4'd0) begin
         clamp_count = 4'd1;
      end else if (v > maxv) begin
         clamp_count = maxv;
      end else begin
         clamp_count = v;
      end
   endfunction

   function automatic logic [6:0] edge_of(input logic [END_W-1:0] e);
      if (e == '0) begin
         edge_of = 7'd0;
      end else if (e - END_W'(1) > END_W'(127)) begin
         edge_of = 7'd127;
      end else begin
         edge_of = 7'(e - END_W'(1));
      end
   endfunction

   function automatic logic [7:0] sat255(input logic [END_W-1:0] v);
      sat255 = (v > END_W'(255)) ? 8'd255 : v[7:0];
   endfunction

endpackage

>>> hw/rtl/tile_partition_ctu_mapper.sv
// tile partition ctu mapper top level: maps a raster ctu address to its tile
// depends on tpcm_pkg

// One address beat is taken per cycle while rsp_ready does not hold the
// output; each beat passes the input register, four division stages, tile
// search and output register. The address-by-width division is cut up to four
// quotient bits per stage. Tile boundaries are derived from the configuration registers in a
// three-register chain, so configuration must only be written while the
// block is idle; the first address may follow the write in the next cycle.
module tile_partition_ctu_mapper (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [tpcm_pkg::ADDR_W-1:0] req_ctu_address,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [5:0]                  rsp_tile_index,
   output logic [2:0]                  rsp_tile_column,
   output logic [2:0]                  rsp_tile_row,
   output logic [7:0]                  rsp_tile_width,
   output logic [7:0]                  rsp_tile_height,
   output logic [6:0]                  rsp_right_edge,
   output logic [6:0]                  rsp_bottom_edge,
   output logic [tpcm_pkg::ADDR_W-1:0] rsp_first_ctu,
   output logic                        rsp_size_error,
   output logic                        rsp_out_of_range,
   input  logic                        csr_write_enable,
   input  logic [2:0]                  csr_index,
   input  logic [63:0]                 csr_write_data
);
   import tpcm_pkg::*;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [DIM_W-1:0]  rem;
      logic [ADDR_W-1:0] quot;
      logic              oor;
   } div_stage_type;

   typedef struct packed {
      logic [2:0] col;
      logic [2:0] row;
      logic       oor;
   } pos_stage_type;

   localparam int NSTG = 7;

   // configuration registers
   logic [PIX_W-1:0] pic_width_ff, pic_height_ff;
   logic [3:0]       tile_cols_ff, tile_rows_ff;
   logic             uniform_ff;
   logic [63:0]      column_widths_ff, row_heights_ff;

   logic [DIM_W-1:0] dim_total [2];
   logic [3:0]       dim_n [2];
   logic [63:0]      dim_pack [2];

   logic [END_W-1:0] bnd_ff [2][N_TILES], bnd_in [2][N_TILES];
   logic [END_W-1:0] psum_ff [2][N_TILES], psum_in [2][N_TILES];
   logic [END_W-1:0] end_ff [2][N_TILES], end_in [2][N_TILES];
   logic [END_W-1:0] size_ff [2][N_TILES], size_in [2][N_TILES];
   logic             serr_ff, serr_in;
   logic [WH_W-1:0]  wh_ff, wh_in;

   logic [NSTG-1:0]  valid_ff;
   logic [NSTG-1:0]  en;
   div_stage_type    div_ff [5], div_in [5];
   pos_stage_type    pos_ff, pos_in;

   logic [5:0]        idx_in;
   logic [7:0]        tw_in, th_in;
   logic [6:0]        re_in, be_in;
   logic [ADDR_W-1:0] first_in;

   function automatic logic [DIM_W:0] div_step(input logic [DIM_W-1:0] rem,
                                                input logic din,
                                                input logic [DIM_W-1:0] dv);
      logic [DIM_W:0] t;
      t = {rem, din};
      if (t >= {1'b0, dv}) begin
         div_step = {1'b1, DIM_W'(t - {1'b0, dv})};
      end else begin
         div_step = {1'b0, t[DIM_W-1:0]};
      end
   endfunction

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pic_width_ff     <= PIX_W'(1920);
         pic_height_ff    <= PIX_W'(1080);
         tile_cols_ff     <= 4'd1;
         tile_rows_ff     <= 4'd1;
         uniform_ff       <= 1'b1;
         column_widths_ff <= '0;
         row_heights_ff   <= '0;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_PIC_WIDTH:     pic_width_ff     <= csr_write_data[PIX_W-1:0];
            CSR_PIC_HEIGHT:    pic_height_ff    <= csr_write_data[PIX_W-1:0];
            CSR_TILE_COLS:     tile_cols_ff     <= csr_write_data[3:0];
            CSR_TILE_ROWS:     tile_rows_ff     <= csr_write_data[3:0];
            CSR_UNIFORM:       uniform_ff       <= csr_write_data[0];
            CSR_COLUMN_WIDTHS: column_widths_ff <= csr_write_data;
            CSR_ROW_HEIGHTS:   row_heights_ff   <= csr_write_data;
            default: ;
         endcase
      end
   end

   // grid geometry, first derived register
   always_comb begin
      logic [PIX_W:0]              wsum, hsum;
      logic [END_W-1:0]            acc;
      logic [END_W+RCP_W-1:0]      prod;
      logic [2*DIM_W-1:0]          whp;
      wsum = {1'b0, pic_width_ff} + (PIX_W+1)'(CTU_SIZE - 1);
      hsum = {1'b0, pic_height_ff} + (PIX_W+1)'(CTU_SIZE - 1);
      dim_total[0] = wsum[PIX_W:CTU_LOG2];
      dim_total[1] = hsum[PIX_W:CTU_LOG2];
      dim_n[0] = clamp_count(tile_cols_ff, 4'(MAX_TILE_COLS));
      dim_n[1] = clamp_count(tile_rows_ff, 4'(MAX_TILE_ROWS));
      dim_pack[0] = column_widths_ff;
      dim_pack[1] = row_heights_ff;
      for (int d = 0; d < 2; d++) begin
         acc = '0;
         for (int k = 0; k < N_TILES; k++) begin
            prod = (END_W'(k + 1) * END_W'(dim_total[d])) * recip(dim_n[d]);
            bnd_in[d][k] = prod[RCP_SH+END_W-1:RCP_SH];
            acc = acc + END_W'(dim_pack[d][8*k +: 8]);
            psum_in[d][k] = acc;
         end
      end
      whp = dim_total[0] * dim_total[1];
      wh_in = whp[WH_W-1:0];
   end

   // tile ends, second derived register
   always_comb begin
      logic [END_W-1:0] prev, last;
      for (int d = 0; d < 2; d++) begin
         prev = (dim_n[d] >= 4'd2) ? psum_ff[d][3'(dim_n[d] - 4'd2)] : '0;
         last = (END_W'(dim_total[d]) > prev) ? END_W'(dim_total[d]) : prev;
         for (int k = 0; k < N_TILES; k++) begin
            if (uniform_ff) begin
               end_in[d][k] = bnd_ff[d][k];
            end else if (4'(k) < dim_n[d] - 4'd1) begin
               end_in[d][k] = psum_ff[d][k];
            end else begin
               end_in[d][k] = last;
            end
         end
      end
   end

   // tile sizes and size check, third derived register
   always_comb begin
      serr_in = 1'b0;
      for (int d = 0; d < 2; d++) begin
         size_in[d][0] = end_ff[d][0];
         for (int k = 1; k < N_TILES; k++) begin
            size_in[d][k] = end_ff[d][k] - end_ff[d][k-1];
         end
      end
      for (int k = 0; k < N_TILES; k++) begin
         if (4'(k) < dim_n[0] && size_in[0][k] < END_W'(MIN_TILE_W)) serr_in = 1'b1;
         if (4'(k) < dim_n[1] && size_in[1][k] < END_W'(MIN_TILE_H)) serr_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      bnd_ff  <= bnd_in;
      psum_ff <= psum_in;
      end_ff  <= end_in;
      size_ff <= size_in;
      serr_ff <= serr_in;
      wh_ff   <= wh_in;
   end

   // stage enables, bubbles collapse
   always_comb begin
      en[NSTG-1] = !valid_ff[NSTG-1] || rsp_ready;
      for (int s = NSTG - 2; s >= 0; s--) begin
         en[s] = !valid_ff[s] || en[s+1];
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = valid_ff[NSTG-1];

   // division by picture width, up to four quotient bits per stage
   always_comb begin
      div_stage_type  cur;
      logic [DIM_W:0] st;
      div_in[0] = '{addr: req_ctu_address, rem: '0, quot: '0, oor: 1'b0};
      for (int j = 0; j < 4; j++) begin
         cur = div_ff[j];
         if (j == 0) begin
            cur.oor = WH_W'(cur.addr) >= wh_ff;
         end
         for (int b = 0; b < 4; b++) begin
            if (4 * j + b < ADDR_W) begin
               st = div_step(cur.rem, cur.addr[ADDR_W-1], dim_total[0]);
               cur.rem  = st[DIM_W-1:0];
               cur.quot = {cur.quot[ADDR_W-2:0], st[DIM_W]};
               cur.addr = {cur.addr[ADDR_W-2:0], 1'b0};
            end
         end
         div_in[j+1] = cur;
      end
   end

   // tile column and row search
   always_comb begin
      logic [END_W-1:0] x, y;
      if (dim_total[0] == '0) begin
         x = '0;
         y = '0;
      end else begin
         x = END_W'(div_ff[4].rem);
         y = (div_ff[4].quot > ADDR_W'((1 << END_W) - 1)) ? '1 : END_W'(div_ff[4].quot);
      end
      pos_in.col = 3'(dim_n[0] - 4'd1);
      pos_in.row = 3'(dim_n[1] - 4'd1);
      pos_in.oor = div_ff[4].oor;
      for (int k = N_TILES - 1; k >= 0; k--) begin
         if (4'(k) < dim_n[0] && x < end_ff[0][k]) pos_in.col = 3'(k);
         if (4'(k) < dim_n[1] && y < end_ff[1][k]) pos_in.row = 3'(k);
      end
   end

   // result fields
   always_comb begin
      logic [END_W-1:0]         left, top;
      logic [6:0]               idx_full;
      logic [END_W+DIM_W-1:0]   fprod;
      left = (pos_ff.col == 3'd0) ? '0 : end_ff[0][pos_ff.col - 3'd1];
      top  = (pos_ff.row == 3'd0) ? '0 : end_ff[1][pos_ff.row - 3'd1];
      idx_full = 7'(pos_ff.row) * 7'(dim_n[0]) + 7'(pos_ff.col);
      idx_in   = idx_full[5:0];
      tw_in    = sat255(size_ff[0][pos_ff.col]);
      th_in    = sat255(size_ff[1][pos_ff.row]);
      re_in    = edge_of(end_ff[0][pos_ff.col]);
      be_in    = edge_of(end_ff[1][pos_ff.row]);
      fprod    = top * dim_total[0] + (END_W+DIM_W)'(left);
      first_in = fprod[ADDR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[0]) valid_ff[0] <= req_valid;
         for (int s = 1; s < NSTG; s++) begin
            if (en[s]) begin
               valid_ff[s] <= valid_ff[s-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < 5; j++) begin
         if (en[j]) div_ff[j] <= div_in[j];
      end
      if (en[5]) pos_ff <= pos_in;
      if (en[6]) begin
         rsp_tile_index   <= idx_in;
         rsp_tile_column  <= pos_ff.col;
         rsp_tile_row     <= pos_ff.row;
         rsp_tile_width   <= tw_in;
         rsp_tile_height  <= th_in;
         rsp_right_edge   <= re_in;
         rsp_bottom_edge  <= be_in;
         rsp_first_ctu    <= first_in;
         rsp_size_error   <= serr_ff;
         rsp_out_of_range <= pos_ff.oor;
      end
   end

endmodule
